// ===== hdl/wmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wmt_pkg;

    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_SAMPLE_BITS  = 24;

    localparam int IN_W      = 24;
    localparam int OUT_W     = 24;
    localparam int FILL_W    = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd1;

    localparam logic [CFG_W-1:0]  RST_WINDOW_SIZE = 5'd4;

    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIM = 2'd1;

    localparam int ROUND_DIV  = 10;
    localparam int ROUND_BIAS = 5;
    localparam int TRIM_MIN   = 3;

    localparam int                     RND_MAG_W   = 30;
    localparam int                     RND_RECIP_W = 28;
    localparam int                     RND_SHIFT   = 31;
    localparam logic [RND_RECIP_W-1:0] RND_RECIP   = 28'd214748365;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV1,
        ST_DIV2,
        ST_ROUND,
        ST_HOLD
    } wmt_state_t;

    typedef struct packed {
        logic done;
        logic full;
    } wmt_ring_stat_t;

endpackage

`default_nettype wire

// ===== hdl/wmt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wmt_div #(
    parameter int DIV_W = 33,
    parameter int DVS_W = 5
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DIV_W-1:0] dividend,
    input  wire logic        [DVS_W-1:0] divisor,
    output logic                         done,
    output logic signed      [DIV_W-1:0] quotient
);
    import wmt_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] mag_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic             neg_reg;

    logic [DIV_W-1:0] abs_in;
    logic [DVS_W:0]   rem_sh;
    logic             fits;
    logic [DVS_W:0]   rem_sub;

    assign abs_in  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
    assign rem_sh  = {rem_reg, mag_reg[DIV_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= abs_in;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[DIV_W-1];
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? DIV_W'(-mag_reg) : DIV_W'(mag_reg);

endmodule

`default_nettype wire

// ===== hdl/wmt_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wmt_ring #(
    parameter int WINDOW_DEPTH = wmt_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = wmt_pkg::DEF_SAMPLE_BITS,
    parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1),
    parameter int SUM_W        = SAMPLE_BITS + CNT_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic signed [SAMPLE_BITS-1:0] push_sample,
    input  wire logic                          restart,
    input  wire logic        [CNT_W-1:0]       len,
    output wmt_pkg::wmt_ring_stat_t            stat,
    output logic             [CNT_W-1:0]       cnt,
    output logic signed      [SUM_W-1:0]       sum,
    output logic signed      [SAMPLE_BITS-1:0] hi,
    output logic signed      [SAMPLE_BITS-1:0] lo
);
    import wmt_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);

    logic signed [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    logic [IDX_W-1:0] wp_reg;
    logic             full_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic             first_reg;
    logic             done_reg;

    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SAMPLE_BITS-1:0] hi_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;

    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] wr_nxt;
    logic             wr_wrap;
    logic [CNT_W-1:0] rd_nxt;

    assign wr_idx  = (CNT_W'(wp_reg) >= len) ? '0 : wp_reg;
    assign wr_nxt  = CNT_W'(wr_idx) + CNT_W'(1);
    assign wr_wrap = wr_nxt >= len;
    assign rd_nxt  = rd_cnt_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_idx] <= push_sample;
        end
        rd_data_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            full_reg    <= 1'b0;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            rd_cnt_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            first_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg   <= rd_vld_reg & rd_last_reg;
            rd_vld_reg <= busy_reg;
            if (restart)
            begin
                wp_reg   <= '0;
                full_reg <= 1'b0;
            end
            else if (push)
            begin
                wp_reg     <= wr_wrap ? '0 : wr_nxt[IDX_W-1:0];
                full_reg   <= full_reg | wr_wrap;
                cnt_reg    <= (full_reg | wr_wrap) ? len : wr_nxt;
                busy_reg   <= 1'b1;
                rd_cnt_reg <= '0;
                first_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rd_cnt_reg  <= rd_nxt;
                rd_last_reg <= rd_nxt == cnt_reg;
                if (rd_nxt == cnt_reg)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (rd_vld_reg)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (first_reg)
            begin
                sum_reg <= SUM_W'(rd_data_reg);
                hi_reg  <= rd_data_reg;
                lo_reg  <= rd_data_reg;
            end
            else
            begin
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                if (rd_data_reg > hi_reg)
                begin
                    hi_reg <= rd_data_reg;
                end
                if (rd_data_reg < lo_reg)
                begin
                    lo_reg <= rd_data_reg;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.full = full_reg;
    assign cnt       = cnt_reg;
    assign sum       = sum_reg;
    assign hi        = hi_reg;
    assign lo        = lo_reg;

endmodule

`default_nettype wire

// ===== hdl/windowed_mean_trimmed_filter.sv =====
// Windowed mean / trimmed-mean filter.
// Input channel in_valid/in_ready carries one signed sample per item; each item
// writes the sample into a ring window and yields exactly one result item on
// out_valid/out_ready: filtered value, fill_count and window_full.
// cfg_write with cfg_index/cfg_data sets window_size (index 0, restarts the
// window) or filter_mode (index 1); write only while the block is idle.
// After acceptance the window memory is scanned, then the serial divider runs
// (DIV_W = SAMPLE_BITS + clog2(WINDOW_DEPTH+1) + 4, 33 by default). The result
// is then ready for the rounded mean after a rounding step (the divide by ten is
// a reciprocal multiply), for the trimmed mean straight after the divider, and
// straight after the scan when no divide is needed.
// One item is in work at a time; the next can be accepted in the cycle after the
// result loads. in_ready is high in idle even while a finished result waits in
// the output register.
// A stalled receiver holds the result; the next item then completes its work
// and waits until the output register frees.
// Reset clears the window (empty, not wrapped), window_size to 4 and
// filter_mode to rounded mean. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module windowed_mean_trimmed_filter #(
    parameter int WINDOW_DEPTH = wmt_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = wmt_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic        [wmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [wmt_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [wmt_pkg::IN_W-1:0]   sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed      [wmt_pkg::OUT_W-1:0]  filtered,
    output logic             [wmt_pkg::FILL_W-1:0] fill_count,
    output logic                                   window_full
);
    import wmt_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int DIV_W = SUM_W + 4;
    localparam int DVS_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int PROD_W = RND_MAG_W + RND_RECIP_W;

    wmt_state_t state_reg, state_next;

    logic [CFG_W-1:0]  window_size_reg;
    logic [MODE_W-1:0] filter_mode_reg;
    logic [CNT_W-1:0]  len;

    logic                          push;
    logic                          restart;
    wmt_ring_stat_t                ring_stat;
    logic [CNT_W-1:0]              ring_cnt;
    logic signed [SUM_W-1:0]       ring_sum;
    logic signed [SAMPLE_BITS-1:0] ring_hi;
    logic signed [SAMPLE_BITS-1:0] ring_lo;

    logic                    div_start;
    logic signed [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0]        div_divisor;
    logic                    div_done;
    logic signed [DIV_W-1:0] div_quot;

    logic signed [DIV_W-1:0] sum_ext;
    logic signed [DIV_W-1:0] sum_x10;
    logic signed [DIV_W-1:0] trim_num;
    logic                    trim_ok;

    logic signed [DIV_W-1:0] rnd_sum;
    logic [DIV_W-1:0]        rnd_abs;
    logic                    rnd_load;
    logic [RND_MAG_W-1:0]    rnd_mag_reg;
    logic                    rnd_neg_reg;
    logic [PROD_W-1:0]       rnd_prod;
    logic [DIV_W-1:0]        rnd_quot;
    logic signed [DIV_W-1:0] rnd_value;

    logic signed [DIV_W-1:0] res_reg;
    logic                    res_load;
    logic signed [DIV_W-1:0] res_value;
    logic                    out_load;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_val_reg;
    logic [FILL_W-1:0]       out_cnt_reg;
    logic                    out_full_reg;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            len = CNT_W'(1);
        end
        else if (32'(window_size_reg) > 32'(WINDOW_DEPTH))
        begin
            len = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            len = CNT_W'(window_size_reg);
        end
    end

    assign restart = cfg_write && (cfg_index == REG_WINDOW_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= RST_WINDOW_SIZE;
            filter_mode_reg <= MODE_MEAN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                REG_FILTER_MODE: filter_mode_reg <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    wmt_ring #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W)
    ) u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_sample (sample[SAMPLE_BITS-1:0]),
        .restart     (restart),
        .len         (len),
        .stat        (ring_stat),
        .cnt         (ring_cnt),
        .sum         (ring_sum),
        .hi          (ring_hi),
        .lo          (ring_lo)
    );

    wmt_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign sum_ext  = DIV_W'(ring_sum);
    assign sum_x10  = (sum_ext <<< 3) + (sum_ext <<< 1);
    assign trim_num = sum_ext - DIV_W'(ring_hi) - DIV_W'(ring_lo);
    assign trim_ok  = (32'(len) >= TRIM_MIN) && (32'(ring_cnt) >= TRIM_MIN);

    assign rnd_sum   = div_quot + DIV_W'(ROUND_BIAS);
    assign rnd_abs   = rnd_sum[DIV_W-1] ? DIV_W'(-rnd_sum) : DIV_W'(rnd_sum);
    assign rnd_prod  = {{RND_RECIP_W{1'b0}}, rnd_mag_reg} * {{RND_MAG_W{1'b0}}, RND_RECIP};
    assign rnd_quot  = DIV_W'(rnd_prod[PROD_W-1:RND_SHIFT]);
    assign rnd_value = rnd_neg_reg ? DIV_W'(-rnd_quot) : DIV_W'(rnd_quot);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ring_stat.done)
                begin
                    case (filter_mode_reg)
                        MODE_MEAN: state_next = ST_DIV1;
                        MODE_TRIM: state_next = trim_ok ? ST_DIV2 : ST_HOLD;
                        default:   state_next = ST_HOLD;
                    endcase
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = sum_x10;
        div_divisor  = DVS_W'(ring_cnt);
        rnd_load     = 1'b0;
        res_load     = 1'b0;
        res_value    = '0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                if (ring_stat.done)
                begin
                    case (filter_mode_reg)
                        MODE_MEAN:
                        begin
                            div_start = 1'b1;
                        end
                        MODE_TRIM:
                        begin
                            div_start    = trim_ok;
                            div_dividend = trim_num;
                            div_divisor  = DVS_W'(ring_cnt) - DVS_W'(2);
                            res_load     = !trim_ok;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV1:
            begin
                rnd_load = div_done;
            end
            ST_DIV2:
            begin
                res_load  = div_done;
                res_value = div_quot;
            end
            ST_ROUND:
            begin
                res_load  = 1'b1;
                res_value = rnd_value;
            end
            ST_HOLD:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    assign push = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rnd_load)
        begin
            rnd_mag_reg <= RND_MAG_W'(rnd_abs);
            rnd_neg_reg <= rnd_sum[DIV_W-1];
        end
        if (res_load)
        begin
            res_reg <= res_value;
        end
        if (out_load)
        begin
            out_val_reg  <= OUT_W'(res_reg);
            out_cnt_reg  <= FILL_W'(ring_cnt);
            out_full_reg <= ring_stat.full;
        end
    end

    assign out_valid   = out_valid_reg;
    assign filtered    = out_val_reg;
    assign fill_count  = out_cnt_reg;
    assign window_full = out_full_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider finished outside a divide state");

    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ring_stat.done |-> state_reg == ST_SCAN)
        else $error("window scan finished outside the scan state");

    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_HOLD)
        else $error("result raised without passing through hold");

endmodule

`default_nettype wire
